/* rtl/assert_macros.svh */
// assertion macros used by cls_ctrl
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CLS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define CLS_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define CLS_ASSERT(label, clk, rst_n, prop)

`define CLS_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* rtl/cls_pkg.sv */
// shared constants and types of the cursor list store
// used by cls_mem, cls_ctrl and cursor_list_store
package cls_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned OP_W     = 4;
  localparam int unsigned ST_W     = 2;

  localparam int unsigned IN_BITS  = OP_W + VAL_W + CNT_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = 2 * CNT_W + 3 + ST_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_CLEAR  = 4'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 4'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 4'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 4'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 4'd4;
  localparam logic [OP_W-1:0] OP_HEAD   = 4'd5;
  localparam logic [OP_W-1:0] OP_TAIL   = 4'd6;
  localparam logic [OP_W-1:0] OP_NEXT   = 4'd7;
  localparam logic [OP_W-1:0] OP_BACK   = 4'd8;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_POS  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             at_tail;
    logic             at_head;
    logic             found;
    logic [CNT_W-1:0] cursor;
    logic [CNT_W-1:0] length;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/cls_mem.sv */
// entry storage: one write port and one read port with registered data
// depends on cls_pkg
module cls_mem (
  input  logic                      clk_i,
  input  cls_pkg::mem_req_t         req_i,
  output logic [cls_pkg::VAL_W-1:0] rdata_o
);

  logic [cls_pkg::VAL_W-1:0] mem_q [cls_pkg::CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

/* rtl/cls_ctrl.sv */
// sequencer: decodes one operation and walks the store one entry a cycle
// with a single address counter and one word comparator; depends on cls_pkg
`include "assert_macros.svh"

module cls_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  cls_pkg::cmd_t             cmd_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output cls_pkg::res_t             res_o,
  output cls_pkg::mem_req_t         mem_req_o,
  input  logic [cls_pkg::VAL_W-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_DOWN,
    S_FIND,
    S_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [cls_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [cls_pkg::CNT_W-1:0] ptr_q, ptr_d;
  logic                      pend_q, pend_d;
  logic                      found_q, found_d;
  logic [cls_pkg::ST_W-1:0]  status_q, status_d;
  logic [cls_pkg::VAL_W-1:0] val_q, val_d;
  logic [cls_pkg::CNT_W-1:0] pos_q, pos_d;
  logic [cls_pkg::CNT_W-1:0] idx_q, idx_d;
  logic [cls_pkg::CNT_W-1:0] pend_addr_q, pend_addr_d;
  logic [cls_pkg::CNT_W-1:0] idx_dec, idx_inc, cnt_dec;
  logic                      hit;

  assign idx_dec = idx_q - 1'b1;
  assign idx_inc = idx_q + 1'b1;
  assign cnt_dec = cnt_q - 1'b1;
  assign hit     = pend_q && (mem_rdata_i == val_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    found_d     = found_q;
    status_d    = status_q;
    val_d       = val_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    pend_addr_d = pend_addr_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = pend_addr_q[cls_pkg::IDX_W-1:0];
    mem_req_o.wdata = mem_rdata_i;
    mem_req_o.raddr = idx_q[cls_pkg::IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          val_d    = cmd_i.value;
          pos_d    = cmd_i.position;
          found_d  = 1'b0;
          status_d = cls_pkg::ST_OK;
          pend_d   = 1'b0;
          state_d  = S_DONE;
          unique case (cmd_i.operation)
            cls_pkg::OP_CLEAR: begin
              cnt_d = '0;
              ptr_d = '0;
            end
            cls_pkg::OP_APPEND: begin
              if (cnt_q >= cls_pkg::CNT_W'(cls_pkg::CAPACITY)) begin
                status_d = cls_pkg::ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = cnt_q[cls_pkg::IDX_W-1:0];
                mem_req_o.wdata = cmd_i.value;
                cnt_d           = cnt_q + 1'b1;
              end
            end
            cls_pkg::OP_INSERT: begin
              if (cnt_q >= cls_pkg::CNT_W'(cls_pkg::CAPACITY)) begin
                status_d = cls_pkg::ST_FULL;
              end else if (cmd_i.position > cnt_q) begin
                status_d = cls_pkg::ST_POS;
              end else begin
                idx_d   = cnt_q;
                state_d = S_UP;
              end
            end
            cls_pkg::OP_REMOVE: begin
              if (cmd_i.position >= cnt_q) begin
                status_d = cls_pkg::ST_POS;
              end else begin
                idx_d   = cmd_i.position;
                state_d = S_DOWN;
              end
            end
            cls_pkg::OP_FIND: begin
              idx_d   = ptr_q;
              state_d = S_FIND;
            end
            cls_pkg::OP_HEAD: ptr_d = '0;
            cls_pkg::OP_TAIL: ptr_d = cnt_q;
            cls_pkg::OP_NEXT: begin
              if (ptr_q != cnt_q) begin
                ptr_d = ptr_q + 1'b1;
              end
            end
            cls_pkg::OP_BACK: begin
              if (ptr_q != '0) begin
                ptr_d = ptr_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      // shift up: read idx-1, write it to idx in the following cycle
      S_UP: begin
        mem_req_o.we = pend_q;
        if (idx_q > pos_q) begin
          mem_req_o.raddr = idx_dec[cls_pkg::IDX_W-1:0];
          pend_d          = 1'b1;
          pend_addr_d     = idx_q;
          idx_d           = idx_dec;
        end else begin
          pend_d  = 1'b0;
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q[cls_pkg::IDX_W-1:0];
        mem_req_o.wdata = val_q;
        cnt_d           = cnt_q + 1'b1;
        state_d         = S_DONE;
      end
      // shift down: read idx+1, write it to idx in the following cycle
      S_DOWN: begin
        mem_req_o.we = pend_q;
        if (idx_inc < cnt_q) begin
          mem_req_o.raddr = idx_inc[cls_pkg::IDX_W-1:0];
          pend_d          = 1'b1;
          pend_addr_d     = idx_q;
          idx_d           = idx_inc;
        end else begin
          pend_d  = 1'b0;
          cnt_d   = cnt_dec;
          if (ptr_q > cnt_dec) begin
            ptr_d = cnt_dec;
          end
          state_d = S_DONE;
        end
      end
      S_FIND: begin
        if (hit) begin
          ptr_d   = pend_addr_q;
          found_d = 1'b1;
          pend_d  = 1'b0;
          state_d = S_DONE;
        end else if (idx_q < cnt_q) begin
          pend_d      = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = idx_inc;
        end else begin
          ptr_d   = cnt_q;
          pend_d  = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      status_q <= cls_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    pos_q       <= pos_d;
    idx_q       <= idx_d;
    pend_addr_q <= pend_addr_d;
  end

  assign cmd_ready_o    = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_DONE);
  assign res_o.length   = cnt_q;
  assign res_o.cursor   = ptr_q;
  assign res_o.found    = found_q;
  assign res_o.at_head  = (ptr_q == '0);
  assign res_o.at_tail  = (ptr_q == cnt_q);
  assign res_o.status   = status_q;

  `CLS_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > cls_pkg::CNT_W'(cls_pkg::CAPACITY))
  `CLS_NEVER(a_ptr_range, clk_i, rst_ni, ptr_q > cnt_q)
  `CLS_ASSERT(a_find_in_range, clk_i, rst_ni, (state_q == S_FIND && pend_q) |-> (pend_addr_q < cnt_q))
  `CLS_ASSERT(a_found_hit, clk_i, rst_ni, (res_valid_o && found_q) |-> (ptr_q < cnt_q))
  `CLS_ASSERT(a_done_hold, clk_i, rst_ni, (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(cnt_q) && $stable(ptr_q)))

endmodule

/* rtl/cursor_list_store.sv */
// Cursor list store: an ordered list of up to 64 words of 64 bits with a
// cursor. Each transfer on the slave side is one operation and gives exactly
// one result transfer on the master side. Clear, append, head, tail, next,
// back and unused codes need no walk; insert walks from the length down to
// the position, remove from the position up to the length and find from the
// cursor at most up to the length, one entry per cycle, because the entry
// memory has a single read port and registered read data. A new operation
// is taken while the previous result still waits on the master side. No
// clearing pass after reset: entries at or beyond the length are never read.
// depends on cls_pkg, cls_ctrl and cls_mem
module cursor_list_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // operation [3:0], value [67:4], position [74:68]
  input  logic [cls_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // length [6:0], cursor [13:7], found, at_head, at_tail, status [18:17]
  output logic [cls_pkg::OUT_W-1:0] m_axis_tdata
);

  cls_pkg::cmd_t             cmd;
  cls_pkg::res_t             res;
  cls_pkg::res_t             res_q;
  cls_pkg::mem_req_t         mem_req;
  logic [cls_pkg::VAL_W-1:0] mem_rdata;
  logic                      res_valid;
  logic                      res_ready;
  logic                      out_valid_q;

  assign cmd.operation = s_axis_tdata[cls_pkg::OP_W-1:0];
  assign cmd.value     = s_axis_tdata[cls_pkg::OP_W +: cls_pkg::VAL_W];
  assign cmd.position  = s_axis_tdata[cls_pkg::OP_W + cls_pkg::VAL_W +: cls_pkg::CNT_W];

  assign res_ready = !out_valid_q || m_axis_tready;

  cls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  cls_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(cls_pkg::OUT_W - cls_pkg::OUT_BITS){1'b0}}, res_q};

endmodule

/* bench/testbench.sv */
// self-checking bench for cursor_list_store: directed edge cases, a full-store pass and
// random list traffic under random source gaps and sink stalls
// depends on cls_pkg and the cursor_list_store rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [cls_pkg::OP_W-1:0] OP_UNUSED_LO = 4'd9;
  localparam logic [cls_pkg::OP_W-1:0] OP_UNUSED_HI = 4'd15;
  localparam logic [cls_pkg::VAL_W-1:0] WORD_ONES   = '1;
  localparam logic [cls_pkg::VAL_W-1:0] WORD_MSB    = {1'b1, {(cls_pkg::VAL_W-1){1'b0}}};
  localparam logic [cls_pkg::CNT_W-1:0] POS_MAX     = '1;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [cls_pkg::IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [cls_pkg::OUT_W-1:0] m_axis_tdata;

  // shadow copy of the list
  logic [cls_pkg::VAL_W-1:0] list_words [cls_pkg::CAPACITY];
  int unsigned list_len = 0;
  int unsigned list_cursor = 0;

  cls_pkg::res_t pending_results [$];
  int unsigned errors = 0;
  int burst_left = 0;
  bit steady = 1'b0;

  cursor_list_store i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cls_pkg::res_t apply_list_op(input logic [cls_pkg::OP_W-1:0] op,
                                                  input logic [cls_pkg::VAL_W-1:0] val,
                                                  input logic [cls_pkg::CNT_W-1:0] pos);
    cls_pkg::res_t r;
    logic [cls_pkg::ST_W-1:0] st;
    logic hit;
    int unsigned i;
    st = cls_pkg::ST_OK;
    hit = 1'b0;
    case (op)
      cls_pkg::OP_CLEAR: begin
        list_len = 0;
        list_cursor = 0;
      end
      cls_pkg::OP_APPEND: begin
        if (list_len >= cls_pkg::CAPACITY) begin
          st = cls_pkg::ST_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      cls_pkg::OP_INSERT: begin
        if (list_len >= cls_pkg::CAPACITY) begin
          st = cls_pkg::ST_FULL;
        end else if (pos > list_len) begin
          st = cls_pkg::ST_POS;
        end else begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = val;
          list_len++;
        end
      end
      cls_pkg::OP_REMOVE: begin
        if (pos >= list_len) begin
          st = cls_pkg::ST_POS;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          if (list_cursor > list_len) list_cursor = list_len;
        end
      end
      cls_pkg::OP_FIND: begin
        i = list_cursor;
        while (i < list_len && list_words[i] != val) i++;
        if (i < list_len) begin
          list_cursor = i;
          hit = 1'b1;
        end else begin
          list_cursor = list_len;
        end
      end
      cls_pkg::OP_HEAD: list_cursor = 0;
      cls_pkg::OP_TAIL: list_cursor = list_len;
      cls_pkg::OP_NEXT: begin
        if (list_cursor != list_len) list_cursor++;
      end
      cls_pkg::OP_BACK: begin
        if (list_cursor != 0) list_cursor--;
      end
      default: ;
    endcase
    r.length  = cls_pkg::CNT_W'(list_len);
    r.cursor  = cls_pkg::CNT_W'(list_cursor);
    r.found   = hit;
    r.at_head = (list_cursor == 0);
    r.at_tail = (list_cursor == list_len);
    r.status  = st;
    return r;
  endfunction

  task automatic send_op(input logic [cls_pkg::OP_W-1:0] op,
                         input logic [cls_pkg::VAL_W-1:0] val,
                         input logic [cls_pkg::CNT_W-1:0] pos);
    logic [cls_pkg::IN_W-1:0] word;
    word = '0;
    word[cls_pkg::OP_W-1:0] = op;
    word[cls_pkg::OP_W+:cls_pkg::VAL_W] = val;
    word[cls_pkg::OP_W+cls_pkg::VAL_W+:cls_pkg::CNT_W] = pos;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(apply_list_op(op, val, pos));
    if (burst_left > 0) begin
      burst_left--;
    end else if (!steady) begin
      burst_left = $urandom_range(0, 12);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [cls_pkg::CNT_W-1:0] exp_v,
                             input logic [cls_pkg::CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cls_pkg::res_t got;
    cls_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[cls_pkg::OUT_BITS-1:0];
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("length", want.length, got.length);
        check_field("cursor", want.cursor, got.cursor);
        check_field("found", cls_pkg::CNT_W'(want.found), cls_pkg::CNT_W'(got.found));
        check_field("at_head", cls_pkg::CNT_W'(want.at_head),
                    cls_pkg::CNT_W'(got.at_head));
        check_field("at_tail", cls_pkg::CNT_W'(want.at_tail),
                    cls_pkg::CNT_W'(got.at_tail));
        check_field("status", cls_pkg::CNT_W'(want.status), cls_pkg::CNT_W'(got.status));
      end
    end
  end

  // sink stall pattern
  initial begin
    int hi_run;
    int lo_run;
    while (!rst_ni) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        hi_run = $urandom_range(100, 300);
      end else begin
        hi_run = $urandom_range(1, 8);
      end
      lo_run = $urandom_range(0, 7);
      m_axis_tready <= 1'b1;
      repeat (hi_run) @(posedge clk);
      if (lo_run > 0) begin
        m_axis_tready <= 1'b0;
        repeat (lo_run) @(posedge clk);
      end
    end
  end

  function automatic logic [cls_pkg::VAL_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35 && list_len > 0) begin
      return list_words[$urandom_range(0, list_len - 1)];
    end else if (roll < 50) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return WORD_ONES;
        2: return WORD_MSB;
        default: return cls_pkg::VAL_W'($urandom_range(0, 3));
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [cls_pkg::CNT_W-1:0] pick_position(input int unsigned upper);
    if ($urandom_range(0, 9) == 0) return cls_pkg::CNT_W'($urandom_range(0, POS_MAX));
    return cls_pkg::CNT_W'($urandom_range(0, upper));
  endfunction

  task automatic test_directed_edges();
    send_op(cls_pkg::OP_NEXT, '0, '0);
    send_op(cls_pkg::OP_BACK, WORD_ONES, POS_MAX);
    send_op(cls_pkg::OP_REMOVE, '0, '0);
    send_op(cls_pkg::OP_INSERT, WORD_ONES, 7'd1);
    send_op(cls_pkg::OP_FIND, '0, '0);
    send_op(cls_pkg::OP_APPEND, WORD_ONES, '0);
    send_op(cls_pkg::OP_INSERT, '0, 7'd0);
    send_op(cls_pkg::OP_INSERT, WORD_MSB | 64'd1, 7'd2);
    send_op(cls_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 7'd1);
    send_op(cls_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, POS_MAX);
    send_op(cls_pkg::OP_HEAD, '0, '0);
    send_op(cls_pkg::OP_FIND, WORD_ONES, '0);
    send_op(cls_pkg::OP_FIND, WORD_ONES, '0);
    send_op(cls_pkg::OP_NEXT, '0, '0);
    send_op(cls_pkg::OP_FIND, '0, '0);
    send_op(cls_pkg::OP_NEXT, '0, '0);
    send_op(cls_pkg::OP_BACK, '0, '0);
    send_op(cls_pkg::OP_TAIL, '0, '0);
    send_op(cls_pkg::OP_REMOVE, '0, 7'd3);
    send_op(cls_pkg::OP_REMOVE, '0, 7'd3);
    send_op(cls_pkg::OP_REMOVE, '0, POS_MAX);
    send_op(cls_pkg::OP_REMOVE, '0, 7'd0);
    send_op(OP_UNUSED_LO, WORD_ONES, POS_MAX);
    send_op(OP_UNUSED_HI, 64'h0123_4567_89AB_CDEF, 7'd5);
    send_op(cls_pkg::OP_CLEAR, '0, '0);
  endtask

  task automatic test_full_store();
    steady = 1'b0;
    send_op(cls_pkg::OP_CLEAR, '0, '0);
    while (list_len < cls_pkg::CAPACITY) begin
      if ($urandom_range(0, 1) == 0) begin
        send_op(cls_pkg::OP_APPEND, pick_word(), '0);
      end else begin
        send_op(cls_pkg::OP_INSERT, pick_word(),
                cls_pkg::CNT_W'($urandom_range(0, list_len)));
      end
    end
    send_op(cls_pkg::OP_APPEND, pick_word(), '0);
    send_op(cls_pkg::OP_INSERT, pick_word(), POS_MAX);
    send_op(cls_pkg::OP_INSERT, pick_word(), '0);
    send_op(cls_pkg::OP_TAIL, '0, '0);
    send_op(cls_pkg::OP_FIND, list_words[0], '0);
    send_op(cls_pkg::OP_HEAD, '0, '0);
    send_op(cls_pkg::OP_FIND, list_words[cls_pkg::CAPACITY-1], '0);
    send_op(cls_pkg::OP_TAIL, '0, '0);
    send_op(cls_pkg::OP_REMOVE, '0, '0);
    send_op(cls_pkg::OP_REMOVE, '0, cls_pkg::CNT_W'(cls_pkg::CAPACITY));
    send_op(cls_pkg::OP_INSERT, pick_word(), cls_pkg::CNT_W'(list_len));
    send_op(cls_pkg::OP_REMOVE, '0, cls_pkg::CNT_W'(cls_pkg::CAPACITY-1));
  endtask

  task automatic test_random_traffic(input int total);
    int sent;
    int phase_left;
    int roll;
    int w_app;
    int w_ins;
    int w_rem;
    sent = 0;
    phase_left = 0;
    w_app = 0;
    w_ins = 0;
    w_rem = 0;
    while (sent < total) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 90);
        steady = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 2))
          0: begin w_app = 40; w_ins = 30; w_rem = 8; end
          1: begin w_app = 10; w_ins = 10; w_rem = 45; end
          default: begin w_app = 20; w_ins = 20; w_rem = 20; end
        endcase
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < w_app) begin
        send_op(cls_pkg::OP_APPEND, pick_word(), pick_position(POS_MAX));
      end else if (roll < w_app + w_ins) begin
        send_op(cls_pkg::OP_INSERT, pick_word(), pick_position(list_len));
      end else if (roll < w_app + w_ins + w_rem) begin
        send_op(cls_pkg::OP_REMOVE, pick_word(),
                pick_position(list_len > 0 ? list_len - 1 : POS_MAX));
      end else if (roll < 97) begin
        case ($urandom_range(0, 6))
          0, 1: send_op(cls_pkg::OP_FIND, pick_word(), pick_position(POS_MAX));
          2: send_op(cls_pkg::OP_HEAD, pick_word(), pick_position(POS_MAX));
          3: send_op(cls_pkg::OP_TAIL, pick_word(), pick_position(POS_MAX));
          4: send_op(cls_pkg::OP_NEXT, pick_word(), pick_position(POS_MAX));
          default: send_op(cls_pkg::OP_BACK, pick_word(), pick_position(POS_MAX));
        endcase
      end else if (roll < 98) begin
        send_op(cls_pkg::OP_CLEAR, pick_word(), pick_position(POS_MAX));
      end else begin
        send_op(cls_pkg::OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), pick_word(),
                pick_position(POS_MAX));
        sent--;
      end
      sent++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_full_store();
    test_random_traffic(1200);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
